@@ sv/bsfr_pkg.sv @@
package bsfr_pkg;

	// Frame store geometry
	localparam int FRAME_DEPTH = 64;
	localparam int ADDR_W      = $clog2(FRAME_DEPTH);
	localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

	// Reflected CRC-8 polynomial, init zero
	localparam logic [7:0] CRC_POLY = 8'h8C;

	// Register reset values
	localparam logic [7:0] START_RST  = 8'h02;
	localparam logic [7:0] END_RST    = 8'h03;
	localparam logic [7:0] ESCAPE_RST = 8'h10;
	localparam logic [7:0] MASK_RST   = 8'h20;
	localparam logic       CRC_EN_RST = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_RESTART   = 2'd1,
		ERR_MALFORMED = 2'd2,
		ERR_CRC       = 2'd3
	} err_kind_t;

	typedef enum logic [2:0] {
		REG_START  = 3'd0,
		REG_END    = 3'd1,
		REG_ESCAPE = 3'd2,
		REG_MASK   = 3'd3,
		REG_CRC_EN = 3'd4
	} reg_index_t;

	// Command from the parser to the play-out sequencer
	typedef struct packed {
		logic             valid;
		logic             err;
		err_kind_t        kind;
		logic [CNT_W-1:0] len;
	} play_cmd_t;

	// Status back from the play-out sequencer
	typedef struct packed {
		logic busy;
		logic hold;
	} play_sts_t;

	// One byte folded into a reflected CRC-8
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ sv/bsfr_store.sv @@
module bsfr_store
	import bsfr_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem_q [FRAME_DEPTH];
	logic [7:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/bsfr_parse.sv @@
module bsfr_parse
	import bsfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  logic [7:0]        rx_byte,
	input  play_sts_t         sts,
	output play_cmd_t         cmd,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [7:0]        wr_data
);

	logic [7:0]       start_q, end_q, escape_q, mask_q;
	logic             crc_en_q;
	logic [CNT_W-1:0] count_q;
	logic             in_frame_q;
	logic             esc_q;
	logic [7:0]       crc_q;
	logic [7:0]       prev_q;

	logic             acc;
	logic             is_start, is_end, is_esc;
	logic [7:0]       data_b;
	logic [CNT_W-1:0] need, len;
	logic             good;
	logic             room;

	assign cfg_ready = 1'b1;
	assign rx_stall  = sts.busy | sts.hold;
	assign acc       = rx_valid & ~rx_stall;

	assign is_start = (rx_byte == start_q);
	assign is_end   = (rx_byte == end_q);
	assign is_esc   = (rx_byte == escape_q);
	assign data_b   = esc_q ? (rx_byte ^ mask_q) : rx_byte;
	assign need     = crc_en_q ? CNT_W'(2) : CNT_W'(1);
	assign len      = count_q - {{(CNT_W-1){1'b0}}, crc_en_q};
	assign good     = in_frame_q & ~esc_q & (count_q >= need);
	assign room     = (count_q < CNT_W'(FRAME_DEPTH));

	assign wr_addr = count_q[ADDR_W-1:0];
	assign wr_data = data_b;

	// Classify the request: start beats end, end beats escape
	always_comb begin
		cmd   = '0;
		wr_en = 1'b0;
		if (acc) begin
			priority if (is_start) begin
				if (count_q != '0) begin
					cmd.valid = 1'b1;
					cmd.err   = 1'b1;
					cmd.kind  = ERR_RESTART;
				end
			end else if (is_end) begin
				cmd.valid = 1'b1;
				cmd.len   = len;
				if (!good) begin
					cmd.err  = 1'b1;
					cmd.kind = ERR_MALFORMED;
				end else if (crc_en_q && (prev_q != crc_q)) begin
					cmd.err  = 1'b1;
					cmd.kind = ERR_CRC;
				end
			end else if (in_frame_q && !is_esc && room) begin
				wr_en = 1'b1;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RST;
			end_q    <= END_RST;
			escape_q <= ESCAPE_RST;
			mask_q   <= MASK_RST;
			crc_en_q <= CRC_EN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START:  start_q  <= cfg_data;
				REG_END:    end_q    <= cfg_data;
				REG_ESCAPE: escape_q <= cfg_data;
				REG_MASK:   mask_q   <= cfg_data;
				REG_CRC_EN: crc_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			crc_q      <= '0;
		end else if (acc) begin
			priority if (is_start) begin
				count_q    <= '0;
				crc_q      <= '0;
				in_frame_q <= 1'b1;
				esc_q      <= 1'b0;
			end else if (is_end) begin
				count_q    <= '0;
				crc_q      <= '0;
				in_frame_q <= 1'b0;
				esc_q      <= 1'b0;
			end else if (!in_frame_q) begin
				// stray byte outside a frame
			end else if (is_esc) begin
				esc_q <= 1'b1;
			end else if (!room) begin
				// overflow: drop the frame silently
				count_q    <= '0;
				crc_q      <= '0;
				in_frame_q <= 1'b0;
				esc_q      <= 1'b0;
			end else begin
				esc_q   <= 1'b0;
				count_q <= count_q + CNT_W'(1);
				if (count_q != '0) begin
					crc_q <= crc_fold(crc_q, prev_q);
				end
			end
		end
	end

	// Copy of the newest stored byte, saves a memory read for the CRC
	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_q <= data_b;
		end
	end

endmodule

@@ sv/bsfr_play.sv @@
module bsfr_play
	import bsfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  play_cmd_t         cmd,
	output play_sts_t         sts,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [7:0]        rd_data,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [7:0]        payload_byte,
	output logic              last_of_frame,
	output logic [1:0]        error_kind
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] len_q;
	logic             res_valid_q;
	logic [7:0]       payload_q;
	logic             last_q;
	logic [1:0]       kind_q;

	logic             out_free;
	logic             is_last;

	assign out_free = ~res_valid_q | ~res_stall;
	assign is_last  = (idx_q == (len_q - CNT_W'(1)));

	assign sts.busy = (state_q != ST_IDLE);
	assign sts.hold = res_valid_q & res_stall;

	assign rd_en   = (state_q == ST_READ);
	assign rd_addr = idx_q[ADDR_W-1:0];

	assign res_valid     = res_valid_q;
	assign payload_byte  = payload_q;
	assign last_of_frame = last_q;
	assign error_kind    = kind_q;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			len_q       <= '0;
			res_valid_q <= 1'b0;
			payload_q   <= '0;
			last_q      <= 1'b0;
			kind_q      <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						if (cmd.err) begin
							res_valid_q <= 1'b1;
							payload_q   <= '0;
							last_q      <= 1'b1;
							kind_q      <= cmd.kind;
						end else begin
							idx_q   <= '0;
							len_q   <= cmd.len;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						payload_q   <= rd_data;
						last_q      <= is_last;
						kind_q      <= ERR_NONE;
						idx_q       <= idx_q + CNT_W'(1);
						state_q     <= is_last ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/byte_stuffed_frame_receiver.sv @@
// Received bytes are taken one per cycle while rx_stall is low; stored bytes, and a start
// byte with none stored, give no result. An error result appears in the cycle after the
// request that causes it. A good end byte plays the frame out of the store, each payload
// byte by a memory read, then a result register load; requests are held off meanwhile.
// Reset clears frame state and restores register defaults; the frame store is not cleared.
module byte_stuffed_frame_receiver
	import bsfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] payload_byte,
	output logic       last_of_frame,
	output logic [1:0] error_kind
);

	play_cmd_t         cmd;
	play_sts_t         sts;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	bsfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.sts       (sts),
		.cmd       (cmd),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	bsfr_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bsfr_play u_play (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.payload_byte  (payload_byte),
		.last_of_frame (last_of_frame),
		.error_kind    (error_kind)
	);

`ifndef SYNTHESIS
	// No store write while a frame is being played out
	a_no_write_in_play: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !sts.busy)
		else $error("frame store written during play-out");

	// A good-frame command starts the sequencer
	a_play_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && !cmd.err) |=> sts.busy)
		else $error("play-out did not start");

	// Error results carry a zero byte and the last mark
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && error_kind != ERR_NONE) |-> (payload_byte == 8'h00 && last_of_frame))
		else $error("malformed error result");
`endif

endmodule
